// ----- design/lpd_pkg.sv -----
// Shared constants and types for the length-prefix deframer.
package lpd_pkg;

  localparam int PREFIX_BYTES = 4;
  localparam int LEN_W        = PREFIX_BYTES * 8;
  localparam int SHIFT_W      = (PREFIX_BYTES > 1) ? (PREFIX_BYTES - 1) * 8 : 8;
  localparam int CNT_W        = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam int CMP_W        = (LEN_W > 32) ? LEN_W : 32;
  localparam logic [31:0] MAX_LENGTH_RESET = 32'd131072;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_of_packet;
    logic        last_of_packet;
    logic [31:0] frame_length;
    logic        length_error;
  } result_t;

endpackage

// ----- design/lpd_in_reg.sv -----
// Input register stage for the received byte stream.
module lpd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_byte
);

  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_byte <= s_tdata;
    end
  end

endmodule

// ----- design/lpd_core.sv -----
// Prefix gathering, length check and payload tagging for one byte.
module lpd_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [31:0]     cfg_data,
  input  logic            item_valid,
  input  logic [7:0]      item_byte,
  input  logic            space,
  output logic            take,
  output logic            push,
  output lpd_pkg::result_t result
);

  logic [31:0]                max_length;
  logic [lpd_pkg::CNT_W-1:0]  prefix_count;
  logic [lpd_pkg::SHIFT_W-1:0] prefix_shift;
  logic [31:0]                current_length;
  logic [31:0]                bytes_left;
  logic                       sticky_error;

  logic [lpd_pkg::CNT_W-1:0]  prefix_count_next;
  logic [lpd_pkg::SHIFT_W-1:0] prefix_shift_next;
  logic [31:0]                current_length_next;
  logic [31:0]                bytes_left_next;
  logic                       sticky_error_next;

  logic [lpd_pkg::LEN_W-1:0]  len_full;
  logic [lpd_pkg::CMP_W-1:0]  len_ext;
  logic [31:0]                len_sat;
  logic                       prefix_done;

  assign take     = item_valid && space;
  assign len_full = lpd_pkg::LEN_W'({prefix_shift, item_byte});
  assign len_ext  = lpd_pkg::CMP_W'(len_full);
  assign len_sat  = (len_ext > lpd_pkg::CMP_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                : len_ext[31:0];
  assign prefix_done = (prefix_count == lpd_pkg::CNT_W'(lpd_pkg::PREFIX_BYTES - 1));

  always_comb begin
    prefix_count_next   = prefix_count;
    prefix_shift_next   = prefix_shift;
    current_length_next = current_length;
    bytes_left_next     = bytes_left;
    sticky_error_next   = sticky_error;
    push                = 1'b0;
    result.payload_byte    = item_byte;
    result.first_of_packet = (bytes_left == current_length);
    result.last_of_packet  = (bytes_left == 32'd1);
    result.frame_length    = current_length;
    result.length_error    = 1'b0;
    if (take && !sticky_error) begin
      if (bytes_left != 32'd0) begin
        push            = 1'b1;
        bytes_left_next = bytes_left - 32'd1;
      end else if (!prefix_done) begin
        prefix_shift_next = lpd_pkg::SHIFT_W'({prefix_shift, item_byte});
        prefix_count_next = prefix_count + lpd_pkg::CNT_W'(1);
      end else begin
        prefix_shift_next = '0;
        prefix_count_next = '0;
        if (len_ext > lpd_pkg::CMP_W'(max_length)) begin
          sticky_error_next      = 1'b1;
          push                   = 1'b1;
          result.payload_byte    = 8'd0;
          result.first_of_packet = 1'b0;
          result.last_of_packet  = 1'b0;
          result.frame_length    = len_sat;
          result.length_error    = 1'b1;
        end else if (len_ext != '0) begin
          current_length_next = len_ext[31:0];
          bytes_left_next     = len_ext[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length     <= lpd_pkg::MAX_LENGTH_RESET;
      prefix_count   <= '0;
      prefix_shift   <= '0;
      current_length <= '0;
      bytes_left     <= '0;
      sticky_error   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_length <= cfg_data;
      end
      prefix_count   <= prefix_count_next;
      prefix_shift   <= prefix_shift_next;
      current_length <= current_length_next;
      bytes_left     <= bytes_left_next;
      sticky_error   <= sticky_error_next;
    end
  end

endmodule

// ----- design/lpd_out_buf.sv -----
// Two-entry result buffer driving the output stream.
module lpd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lpd_pkg::result_t result,
  output logic             space,
  output logic             m_tvalid,
  input  logic             m_tready,
  output lpd_pkg::result_t head
);

  lpd_pkg::result_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign space    = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= result;
    end
  end

endmodule

// ----- design/length_prefix_deframer.sv -----
// Top level of the length-prefix deframer.
//
//   channel  dir  fields
//   s_*      in   tdata[7:0] data_byte
//   m_*      out  tdata payload_byte, frame_length; tlast last_of_packet;
//                 tuser first_of_packet, length_error
//   cfg_*    in   data max_length
//
// One byte per cycle sustained while the result buffer has space; a byte
// moves through the input register, the decode logic and the two-entry
// result buffer, whose head is offered on m_tvalid. Synchronous reset clears
// the control state and restores max_length to 131072. Output stalls are
// absorbed by the result buffer; s_tready falls only when it is full.
module length_prefix_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] payload_byte, [39:8] frame_length
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [0] first_of_packet, [1] length_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic             item_valid;
  logic [7:0]       item_byte;
  logic             take;
  logic             push;
  logic             space;
  lpd_pkg::result_t result;
  lpd_pkg::result_t head;

  assign cfg_ready = 1'b1;

  lpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  lpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .space      (space),
    .take       (take),
    .push       (push),
    .result     (result)
  );

  lpd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .result   (result),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {head.frame_length, head.payload_byte};
  assign m_tlast = head.last_of_packet;
  assign m_tuser = {head.length_error, head.first_of_packet};

endmodule
